>>> src/palette_delta_packet_encoder_assert.svh
// assertion helpers for the palette delta packet encoder
// clock i_clk and active-low reset i_rst_n are taken from the including scope
`ifndef PALETTE_DELTA_PACKET_ENCODER_ASSERT_SVH
`define PALETTE_DELTA_PACKET_ENCODER_ASSERT_SVH

// same-cycle implication
`define PDPE_ASSERT_IMPL(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("pdpe assertion failed");

// next-cycle implication
`define PDPE_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("pdpe assertion failed");

`endif

>>> src/pdpe_pkg.sv
// ----------------------------------------------------------------------------
// pdpe_pkg
// shared constants and types of the palette delta packet encoder
// ----------------------------------------------------------------------------
package pdpe_pkg;

    localparam int MAX_COLORS   = 256;
    localparam int BUFFER_BYTES = 1024;
    localparam int COUNT_W      = $clog2(MAX_COLORS + 1);
    localparam int ADDR_W       = $clog2(BUFFER_BYTES);
    localparam int BYTE_W       = 8;
    localparam int PKT_W        = 16;

    localparam int QUEUE_DEPTH  = 2;
    localparam int QUEUE_PTR_W  = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QUEUE_CNT_W  = $clog2(QUEUE_DEPTH + 1);

    // result slots of one command, emitted lowest first
    localparam int SLOT_CNT_PRE = 0;
    localparam int SLOT_SKIP    = 1;
    localparam int SLOT_RED     = 2;
    localparam int SLOT_GREEN   = 3;
    localparam int SLOT_BLUE    = 4;
    localparam int SLOT_CNT_END = 5;
    localparam int SLOT_PKT_LO  = 6;
    localparam int SLOT_PKT_HI  = 7;
    localparam int SLOT_DONE    = 8;
    localparam int SLOT_N       = 9;

    localparam logic KIND_WRITE = 1'b0;
    localparam logic KIND_DONE  = 1'b1;

    localparam logic [ADDR_W-1:0] PKT_LO_ADDR = ADDR_W'(0);
    localparam logic [ADDR_W-1:0] PKT_HI_ADDR = ADDR_W'(1);
    localparam logic [ADDR_W-1:0] FIRST_PTR   = ADDR_W'(2);

    typedef logic [SLOT_N-1:0] t_slot_mask;

    typedef struct packed {
        t_slot_mask          mask;
        logic [ADDR_W-1:0]   cnt_addr;
        logic [BYTE_W-1:0]   cnt_val;
        logic [ADDR_W-1:0]   skip_addr;
        logic [BYTE_W-1:0]   skip_val;
        logic [ADDR_W-1:0]   data_addr;
        logic [BYTE_W-1:0]   red;
        logic [BYTE_W-1:0]   green;
        logic [BYTE_W-1:0]   blue;
        logic [PKT_W-1:0]    pkt_total;
        logic [ADDR_W-1:0]   end_ptr;
    } t_cmd;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_status;

endpackage

>>> src/palette_delta_packet_encoder.sv
// ----------------------------------------------------------------------------
// palette_delta_packet_encoder
// encodes palette changes as skip/change packets of buffer byte writes
// ----------------------------------------------------------------------------
// One old/new color pair is taken per cycle while the two-entry command
// queue has room; each pair becomes a command of 0 to 8 output words, and
// the output side sends one word per cycle while i_stall is low and a
// command waits, so the sustained rate is set by the output register: an
// equal color inside a skip run yields no word, an equal color closing a
// run yields 1, a changed color 3 (4 when it opens a packet), and the last
// color of a frame adds up to 4 more (run count, two packet count bytes and
// the done word carrying the length).
// color_count must be written only while the block is idle; the block itself does not enforce this.
module palette_delta_packet_encoder (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [pdpe_pkg::COUNT_W-1:0]  i_cfg_color_count,
    input  logic                          i_valid,
    output logic                          o_stall,
    input  logic [pdpe_pkg::BYTE_W-1:0]   i_old_red,
    input  logic [pdpe_pkg::BYTE_W-1:0]   i_old_green,
    input  logic [pdpe_pkg::BYTE_W-1:0]   i_old_blue,
    input  logic [pdpe_pkg::BYTE_W-1:0]   i_new_red,
    input  logic [pdpe_pkg::BYTE_W-1:0]   i_new_green,
    input  logic [pdpe_pkg::BYTE_W-1:0]   i_new_blue,
    output logic                          o_valid,
    input  logic                          i_stall,
    output logic                          o_kind,
    output logic [pdpe_pkg::ADDR_W-1:0]   o_write_address,
    output logic [pdpe_pkg::BYTE_W-1:0]   o_write_value,
    output logic                          o_last
);
    import pdpe_pkg::*;

`include "palette_delta_packet_encoder_assert.svh"

    logic      accept;
    logic      push;
    logic      pop;
    t_cmd      push_cmd;
    t_cmd      head;
    t_q_status q_status;

    assign o_cfg_ready = 1'b1;
    assign o_stall     = q_status.full;
    assign accept      = i_valid && !q_status.full;

    pdpe_front u_front (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cfg_valid       (i_cfg_valid),
        .i_cfg_color_count (i_cfg_color_count),
        .i_accept          (accept),
        .i_old_red         (i_old_red),
        .i_old_green       (i_old_green),
        .i_old_blue        (i_old_blue),
        .i_new_red         (i_new_red),
        .i_new_green       (i_new_green),
        .i_new_blue        (i_new_blue),
        .o_push            (push),
        .o_cmd             (push_cmd)
    );

    pdpe_queue u_queue (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (push),
        .i_push_cmd (push_cmd),
        .i_pop      (pop),
        .o_head     (head),
        .o_status   (q_status)
    );

    pdpe_back u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_head          (head),
        .i_q_status      (q_status),
        .o_pop           (pop),
        .i_stall         (i_stall),
        .o_valid         (o_valid),
        .o_kind          (o_kind),
        .o_write_address (o_write_address),
        .o_write_value   (o_write_value),
        .o_last          (o_last)
    );

    // only the done word ends a frame
    `PDPE_ASSERT_IMPL(a_done_is_last, o_valid, o_kind == o_last)
    // a word appears only when a command was waiting
    `PDPE_ASSERT_IMPL(a_word_from_queue, $rose(o_valid), $past(!q_status.empty))
    // a waiting command reaches a free output register in the next cycle
    `PDPE_ASSERT_NEXT(a_queue_drains, !q_status.empty && (!o_valid || !i_stall), o_valid)

endmodule

>>> src/pdpe_front.sv
// ----------------------------------------------------------------------------
// pdpe_front
// compares each color pair, tracks runs and pointers, and turns the item
// into at most one command for the back end
// ----------------------------------------------------------------------------
module pdpe_front (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_valid,
    input  logic [pdpe_pkg::COUNT_W-1:0]  i_cfg_color_count,
    input  logic                          i_accept,
    input  logic [pdpe_pkg::BYTE_W-1:0]   i_old_red,
    input  logic [pdpe_pkg::BYTE_W-1:0]   i_old_green,
    input  logic [pdpe_pkg::BYTE_W-1:0]   i_old_blue,
    input  logic [pdpe_pkg::BYTE_W-1:0]   i_new_red,
    input  logic [pdpe_pkg::BYTE_W-1:0]   i_new_green,
    input  logic [pdpe_pkg::BYTE_W-1:0]   i_new_blue,
    output logic                          o_push,
    output pdpe_pkg::t_cmd                o_cmd
);
    import pdpe_pkg::*;

    localparam logic [COUNT_W-1:0] MAX_CNT = COUNT_W'(MAX_COLORS);

    logic [COUNT_W-1:0] r_color_count;
    logic [COUNT_W-1:0] r_color_index, n_color_index;
    logic               r_in_run, n_in_run;
    logic [COUNT_W-1:0] r_skip_run, n_skip_run;
    logic [COUNT_W-1:0] r_change_run, n_change_run;
    logic [ADDR_W-1:0]  r_write_ptr, n_write_ptr;
    logic [ADDR_W-1:0]  r_count_slot, n_count_slot;
    logic [PKT_W-1:0]   r_pkt_total, n_pkt_total;

    logic [COUNT_W-1:0] frame_len;
    logic               is_last;
    logic               equal;
    t_cmd               cmd;

    always_comb begin
        if (r_color_count == '0) begin
            frame_len = COUNT_W'(1);
        end else if (r_color_count > MAX_CNT) begin
            frame_len = MAX_CNT;
        end else begin
            frame_len = r_color_count;
        end
    end

    assign is_last = ({1'b0, r_color_index} + (COUNT_W + 1)'(1)) >= {1'b0, frame_len};
    assign equal   = (i_old_red == i_new_red) && (i_old_green == i_new_green)
                     && (i_old_blue == i_new_blue);

    always_comb begin
        n_color_index = r_color_index;
        n_in_run      = r_in_run;
        n_skip_run    = r_skip_run;
        n_change_run  = r_change_run;
        n_write_ptr   = r_write_ptr;
        n_count_slot  = r_count_slot;
        n_pkt_total   = r_pkt_total;
        cmd           = '0;
        cmd.red       = i_new_red;
        cmd.green     = i_new_green;
        cmd.blue      = i_new_blue;

        if (equal) begin
            if (r_in_run) begin
                cmd.mask[SLOT_CNT_PRE] = 1'b1;
                cmd.cnt_addr           = r_count_slot;
                cmd.cnt_val            = r_change_run[BYTE_W-1:0];
                n_in_run               = 1'b0;
                n_skip_run             = COUNT_W'(1);
            end else if (r_skip_run < MAX_CNT) begin
                n_skip_run = r_skip_run + COUNT_W'(1);
            end
        end else begin
            if (!r_in_run) begin
                // open a packet: skip byte now, count byte when the run closes
                cmd.mask[SLOT_SKIP] = 1'b1;
                cmd.skip_addr       = r_write_ptr;
                cmd.skip_val        = r_skip_run[BYTE_W-1:0];
                n_count_slot        = r_write_ptr + ADDR_W'(1);
                n_write_ptr         = r_write_ptr + ADDR_W'(2);
                n_pkt_total         = r_pkt_total + PKT_W'(1);
                n_change_run        = '0;
                n_skip_run          = '0;
                n_in_run            = 1'b1;
            end
            cmd.mask[SLOT_RED]   = 1'b1;
            cmd.mask[SLOT_GREEN] = 1'b1;
            cmd.mask[SLOT_BLUE]  = 1'b1;
            cmd.data_addr        = n_write_ptr;
            n_write_ptr          = n_write_ptr + ADDR_W'(3);
            if (n_change_run < MAX_CNT) begin
                n_change_run = n_change_run + COUNT_W'(1);
            end
        end

        if (is_last) begin
            if (n_in_run) begin
                cmd.mask[SLOT_CNT_END] = 1'b1;
                cmd.cnt_addr           = n_count_slot;
                cmd.cnt_val            = n_change_run[BYTE_W-1:0];
            end
            cmd.mask[SLOT_PKT_LO] = 1'b1;
            cmd.mask[SLOT_PKT_HI] = 1'b1;
            cmd.mask[SLOT_DONE]   = 1'b1;
            cmd.pkt_total         = n_pkt_total;
            cmd.end_ptr           = n_write_ptr;
            n_color_index         = '0;
            n_in_run              = 1'b0;
            n_skip_run            = '0;
            n_change_run          = '0;
            n_write_ptr           = FIRST_PTR;
            n_count_slot          = '0;
            n_pkt_total           = '0;
        end else begin
            n_color_index = r_color_index + COUNT_W'(1);
        end
    end

    // an equal color inside a skip run produces nothing unless it is the last of the frame
    assign o_push = i_accept && (cmd.mask != '0);
    assign o_cmd  = cmd;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_color_count <= MAX_CNT;
            r_color_index <= '0;
            r_in_run      <= 1'b0;
            r_skip_run    <= '0;
            r_change_run  <= '0;
            r_write_ptr   <= FIRST_PTR;
            r_count_slot  <= '0;
            r_pkt_total   <= '0;
        end else begin
            if (i_cfg_valid) begin
                r_color_count <= i_cfg_color_count;
            end
            if (i_accept) begin
                r_color_index <= n_color_index;
                r_in_run      <= n_in_run;
                r_skip_run    <= n_skip_run;
                r_change_run  <= n_change_run;
                r_write_ptr   <= n_write_ptr;
                r_count_slot  <= n_count_slot;
                r_pkt_total   <= n_pkt_total;
            end
        end
    end

endmodule

>>> src/pdpe_queue.sv
// ----------------------------------------------------------------------------
// pdpe_queue
// short command queue between the classifier and the byte sequencer
// ----------------------------------------------------------------------------
module pdpe_queue (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_push,
    input  pdpe_pkg::t_cmd        i_push_cmd,
    input  logic                  i_pop,
    output pdpe_pkg::t_cmd        o_head,
    output pdpe_pkg::t_q_status   o_status
);
    import pdpe_pkg::*;

    t_cmd                   r_entry [QUEUE_DEPTH];
    logic [QUEUE_PTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [QUEUE_PTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [QUEUE_CNT_W-1:0] r_count, n_count;

    function automatic logic [QUEUE_PTR_W-1:0] ptr_inc(input logic [QUEUE_PTR_W-1:0] p);
        logic [QUEUE_PTR_W-1:0] q;
        if (p == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) begin
            q = '0;
        end else begin
            q = p + QUEUE_PTR_W'(1);
        end
        return q;
    endfunction

    assign o_status.full  = (r_count == QUEUE_CNT_W'(QUEUE_DEPTH));
    assign o_status.empty = (r_count == '0);
    assign o_head         = r_entry[r_rd_ptr];

    always_comb begin
        n_wr_ptr = i_push ? ptr_inc(r_wr_ptr) : r_wr_ptr;
        n_rd_ptr = i_pop ? ptr_inc(r_rd_ptr) : r_rd_ptr;
        n_count  = r_count;
        if (i_push && !i_pop) begin
            n_count = r_count + QUEUE_CNT_W'(1);
        end else if (!i_push && i_pop) begin
            n_count = r_count - QUEUE_CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_entry[r_wr_ptr] <= i_push_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

endmodule

>>> src/pdpe_back.sv
// ----------------------------------------------------------------------------
// pdpe_back
// walks the slots of the head command and emits one word per cycle into
// the output register unless i_stall holds it
// ----------------------------------------------------------------------------
module pdpe_back (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  pdpe_pkg::t_cmd                i_head,
    input  pdpe_pkg::t_q_status           i_q_status,
    output logic                          o_pop,
    input  logic                          i_stall,
    output logic                          o_valid,
    output logic                          o_kind,
    output logic [pdpe_pkg::ADDR_W-1:0]   o_write_address,
    output logic [pdpe_pkg::BYTE_W-1:0]   o_write_value,
    output logic                          o_last
);
    import pdpe_pkg::*;

    t_slot_mask        r_sent, n_sent;
    t_slot_mask        remain;
    t_slot_mask        pick;
    logic              load;

    logic              r_valid;
    logic              r_kind, n_kind;
    logic [ADDR_W-1:0] r_addr, n_addr;
    logic [BYTE_W-1:0] r_val, n_val;
    logic              r_last, n_last;

    assign remain = i_head.mask & ~r_sent;
    assign pick   = remain & (~remain + t_slot_mask'(1));
    assign load   = !i_q_status.empty && (!r_valid || !i_stall);
    assign o_pop  = load && (remain == pick);

    always_comb begin
        n_kind = KIND_WRITE;
        n_last = 1'b0;
        n_addr = i_head.cnt_addr;
        n_val  = i_head.cnt_val;
        if (pick[SLOT_SKIP]) begin
            n_addr = i_head.skip_addr;
            n_val  = i_head.skip_val;
        end else if (pick[SLOT_RED]) begin
            n_addr = i_head.data_addr;
            n_val  = i_head.red;
        end else if (pick[SLOT_GREEN]) begin
            n_addr = i_head.data_addr + ADDR_W'(1);
            n_val  = i_head.green;
        end else if (pick[SLOT_BLUE]) begin
            n_addr = i_head.data_addr + ADDR_W'(2);
            n_val  = i_head.blue;
        end else if (pick[SLOT_PKT_LO]) begin
            n_addr = PKT_LO_ADDR;
            n_val  = i_head.pkt_total[BYTE_W-1:0];
        end else if (pick[SLOT_PKT_HI]) begin
            n_addr = PKT_HI_ADDR;
            n_val  = i_head.pkt_total[PKT_W-1:BYTE_W];
        end else if (pick[SLOT_DONE]) begin
            // done marker doubles as the zero pad of an odd length
            n_kind = KIND_DONE;
            n_last = 1'b1;
            n_addr = i_head.end_ptr;
            n_val  = '0;
        end
    end

    always_comb begin
        n_sent = r_sent;
        if (load) begin
            n_sent = o_pop ? '0 : (r_sent | pick);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_sent  <= '0;
        end else begin
            r_sent <= n_sent;
            if (load) begin
                r_valid <= 1'b1;
            end else if (!i_stall) begin
                r_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_kind <= n_kind;
            r_addr <= n_addr;
            r_val  <= n_val;
            r_last <= n_last;
        end
    end

    assign o_valid         = r_valid;
    assign o_kind          = r_kind;
    assign o_write_address = r_addr;
    assign o_write_value   = r_val;
    assign o_last          = r_last;

endmodule
